/* rtl/autoscaling_job_dispatcher_defines.svh */
// Assertion macros shared by the checker of the job dispatcher
`ifndef AUTOSCALING_JOB_DISPATCHER_DEFINES_SVH
`define AUTOSCALING_JOB_DISPATCHER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define AJD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define AJD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ajd_pkg.sv */
// Shared widths, register indexes and constants of the job dispatcher
`default_nettype none

package ajd_pkg;

    localparam int ARRIVALS_W = 8;
    localparam int PENDING_W  = 16;
    localparam int COUNT_W    = 7;
    localparam int DISP_W     = 7;
    localparam int DUR_W      = 8;
    localparam int THR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_JOB_DURATION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_THRESHOLD = 2'd1;

    localparam logic [DUR_W-1:0] DUR_RESET = 8'd5;
    localparam logic [THR_W-1:0] THR_RESET = 16'd100;

    // n / 10 == (n * 205) >> 11, exact for n up to 1028
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_MUL_W = 8;
    localparam int DIV10_SHIFT = 11;

endpackage

`default_nettype wire

/* rtl/ajd_cell.sv */
// One server slot: countdown register and one hop of the dispatch token
`default_nettype none

module ajd_cell #(
    parameter int INDEX = 0,
    parameter int CW    = 7,
    parameter int PW    = 16
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic [ajd_pkg::DUR_W-1:0]   job_duration,
    input  wire logic [CW-1:0]               server_count,
    input  wire logic                        clear_en,
    input  wire logic [CW-1:0]               clear_from,
    input  wire logic                        in_valid,
    input  wire logic [PW-1:0]               in_pending,
    input  wire logic [CW-1:0]               in_dispatched,
    output logic                             out_valid,
    output logic [PW-1:0]                    out_pending,
    output logic [CW-1:0]                    out_dispatched
);

    localparam logic [CW-1:0] SLOT = CW'(INDEX);

    logic [ajd_pkg::DUR_W-1:0] countdown_reg;
    logic [ajd_pkg::DUR_W-1:0] countdown_next;
    logic                      valid_reg;
    logic [PW-1:0]             pending_reg;
    logic [PW-1:0]             pending_next;
    logic [CW-1:0]             dispatched_reg;
    logic [CW-1:0]             dispatched_next;
    logic                      active;
    logic                      idle;
    logic                      take;

    always_comb begin
        active = SLOT < server_count;
        idle   = countdown_reg == '0;
        take   = in_valid && active && idle && (in_pending != '0);

        countdown_next = countdown_reg;
        if (clear_en && (SLOT >= clear_from)) begin
            countdown_next = '0;
        end else if (in_valid && active) begin
            if (take) begin
                countdown_next = job_duration;
            end else if (!idle) begin
                countdown_next = countdown_reg - 1'b1;
            end
        end

        pending_next    = take ? in_pending - 1'b1 : in_pending;
        dispatched_next = take ? in_dispatched + 1'b1 : in_dispatched;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            countdown_reg <= '0;
            valid_reg     <= 1'b0;
        end else begin
            countdown_reg <= countdown_next;
            valid_reg     <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        pending_reg    <= pending_next;
        dispatched_reg <= dispatched_next;
    end

    assign out_valid      = valid_reg;
    assign out_pending    = pending_reg;
    assign out_dispatched = dispatched_reg;

endmodule

`default_nettype wire

/* rtl/autoscaling_job_dispatcher.sv */
// Top level of the autoscaling job dispatcher: sequencer, scaling step and slot chain
`default_nettype none

// Each input word is one tick. The arrivals are added to the pending counter
// (saturating at QUEUE_CAPACITY, dropped flags the loss), then a token carrying
// the pending and dispatched counts walks a chain of MAX_SERVERS slot cells, one
// cell per clock. A tick runs through the accept, inject, walk, multiply, scale
// and done states in that order: the word is accepted, the token is injected and
// hops through the chain, its output is taken, the scaling arithmetic runs in the
// multiply and scale states and the done state loads the result register. A tick
// waits in the done state while an earlier result still waits on m_ready. The
// result register frees the input side: a new word is taken while the previous
// result still waits on m_ready. Configuration writes are taken at any time but
// may only be issued while no tick is in progress.
module autoscaling_job_dispatcher #(
    parameter int MAX_SERVERS    = 64,
    parameter int QUEUE_CAPACITY = 65535
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ajd_pkg::ARRIVALS_W-1:0]    s_arrivals,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [ajd_pkg::PENDING_W-1:0]          m_pending_jobs,
    output logic [ajd_pkg::COUNT_W-1:0]            m_server_count,
    output logic [ajd_pkg::DISP_W-1:0]             m_dispatched,
    output logic                                   m_dropped,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [ajd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ajd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW   = $clog2(QUEUE_CAPACITY + 1);
    localparam int CW   = $clog2(MAX_SERVERS + 1);
    localparam int SW   = PW + ajd_pkg::ARRIVALS_W;
    localparam int PRW  = ajd_pkg::THR_W + 1 + CW;
    localparam int CMPW = PW + PRW;
    localparam int DQW  = CW + ajd_pkg::DIV10_MUL_W;

    localparam logic [PW-1:0] CAP   = PW'(QUEUE_CAPACITY);
    localparam logic [CW-1:0] MAXC  = CW'(MAX_SERVERS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INJECT = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_SCALE  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]                  state_reg;
    logic [2:0]                  state_next;
    logic [ajd_pkg::DUR_W-1:0]   duration_reg;
    logic [ajd_pkg::THR_W-1:0]   threshold_reg;
    logic [PW-1:0]               pending_reg;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               count_next;
    logic [CW-1:0]               disp_reg;
    logic                        dropped_reg;
    logic [PRW-1:0]              prod_reg;
    logic [CW-1:0]               step_reg;

    logic                        in_accept;
    logic                        out_free;
    logic                        overflow;
    logic [PW-1:0]               sum;
    logic [ajd_pkg::THR_W:0]     thr_p1;
    logic [DQW-1:0]              div10;
    logic                        grow;
    logic [CW-1:0]               room;
    logic                        clear_en;

    logic [MAX_SERVERS:0]        tok_valid;
    logic [PW-1:0]               tok_pending    [MAX_SERVERS+1];
    logic [CW-1:0]               tok_dispatched [MAX_SERVERS+1];

    assign s_ready   = state_reg == S_IDLE;
    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;
    assign out_free  = !m_valid || m_ready;
    assign clear_en  = state_reg == S_DONE;

    always_comb begin
        overflow = SW'(s_arrivals) > SW'(CAP - pending_reg);
        sum      = pending_reg + PW'(s_arrivals);
        thr_p1   = {1'b0, threshold_reg} + 1'b1;
        div10    = (DQW'(count_reg) * DQW'(ajd_pkg::DIV10_MUL)) >> ajd_pkg::DIV10_SHIFT;
        grow     = CMPW'(pending_reg) >= CMPW'(prod_reg);
        room     = MAXC - count_reg;
        if (grow) begin
            count_next = (step_reg > room) ? MAXC : count_reg + step_reg;
        end else begin
            count_next = (step_reg >= count_reg) ? ONE_C : count_reg - step_reg;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (in_accept) state_next = S_INJECT;
            S_INJECT: state_next = S_WALK;
            S_WALK:   if (tok_valid[MAX_SERVERS]) state_next = S_MUL;
            S_MUL:    state_next = S_SCALE;
            S_SCALE:  state_next = S_DONE;
            S_DONE:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            duration_reg  <= ajd_pkg::DUR_RESET;
            threshold_reg <= ajd_pkg::THR_RESET;
            pending_reg   <= '0;
            count_reg     <= ONE_C;
            m_valid       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    ajd_pkg::REG_JOB_DURATION:
                        duration_reg <= cfg_data[ajd_pkg::DUR_W-1:0];
                    ajd_pkg::REG_SCALE_THRESHOLD:
                        threshold_reg <= cfg_data[ajd_pkg::THR_W-1:0];
                    default: ;
                endcase
            end
            if (in_accept) begin
                pending_reg <= overflow ? CAP : sum;
            end
            if (state_reg == S_WALK && tok_valid[MAX_SERVERS]) begin
                pending_reg <= tok_pending[MAX_SERVERS];
            end
            if (state_reg == S_SCALE) begin
                count_reg <= count_next;
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            dropped_reg <= overflow;
        end
        if (state_reg == S_WALK && tok_valid[MAX_SERVERS]) begin
            disp_reg <= tok_dispatched[MAX_SERVERS];
        end
        if (state_reg == S_MUL) begin
            prod_reg <= PRW'(thr_p1) * PRW'(count_reg);
            step_reg <= CW'(div10) + 1'b1;
        end
        if (state_reg == S_DONE && out_free) begin
            m_pending_jobs <= ajd_pkg::PENDING_W'(pending_reg);
            m_server_count <= ajd_pkg::COUNT_W'(count_reg);
            m_dispatched   <= ajd_pkg::DISP_W'(disp_reg);
            m_dropped      <= dropped_reg;
        end
    end

    assign tok_valid[0]      = state_reg == S_INJECT;
    assign tok_pending[0]    = pending_reg;
    assign tok_dispatched[0] = '0;

    for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
        ajd_cell #(
            .INDEX (g),
            .CW    (CW),
            .PW    (PW)
        ) u_cell (
            .aclk           (aclk),
            .aresetn        (aresetn),
            .job_duration   (duration_reg),
            .server_count   (count_reg),
            .clear_en       (clear_en),
            .clear_from     (count_reg),
            .in_valid       (tok_valid[g]),
            .in_pending     (tok_pending[g]),
            .in_dispatched  (tok_dispatched[g]),
            .out_valid      (tok_valid[g+1]),
            .out_pending    (tok_pending[g+1]),
            .out_dispatched (tok_dispatched[g+1])
        );
    end

endmodule

`default_nettype wire

/* rtl/ajd_checker.sv */
// Port-level checks of the job dispatcher and their binding to the top level
`default_nettype none

`include "autoscaling_job_dispatcher_defines.svh"

module ajd_checker #(
    parameter int MAX_SERVERS    = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    input  wire logic                              s_ready,
    input  wire logic                              m_valid,
    input  wire logic                              m_ready,
    input  wire logic [ajd_pkg::PENDING_W-1:0]     m_pending_jobs,
    input  wire logic [ajd_pkg::COUNT_W-1:0]       m_server_count,
    input  wire logic [ajd_pkg::DISP_W-1:0]        m_dispatched,
    input  wire logic                              m_dropped
);

    localparam bit WIDE = MAX_SERVERS > 127;

    `AJD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready,
        !s_ready, "input accepted while a tick is still in progress")

    `AJD_ASSERT_NOW(a_count_range, aclk, aresetn, m_valid,
        WIDE || (m_server_count != '0 && m_server_count <= MAX_SERVERS),
        "server count outside 1..MAX_SERVERS")

    `AJD_ASSERT_NOW(a_dispatch_range, aclk, aresetn, m_valid,
        WIDE || (m_dispatched <= MAX_SERVERS), "more jobs dispatched than slots")

    `AJD_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_pending_jobs) && $stable(m_server_count)
            && $stable(m_dispatched) && $stable(m_dropped),
        "stalled result word changed")

endmodule

bind autoscaling_job_dispatcher ajd_checker #(
    .MAX_SERVERS    (MAX_SERVERS)
) u_ajd_checker (.*);

`default_nettype wire
